### rtl/rhp_pkg.sv
// Shared types and constants of the RTP header parser.
`timescale 1ns / 1ps
package rhp_pkg;

   // Longest packet taken before the over-long status is raised
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);

   // Fixed header length and extension profiles
   localparam logic [6:0]  FIXED_HDR_BYTES = 7'd12;
   localparam logic [15:0] PROFILE_ONE     = 16'hBEDE;
   localparam logic [15:0] PROFILE_TWO     = 16'h1000;
   localparam logic [1:0]  RTP_VERSION     = 2'd2;

   // Bit widths of the stream buses
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_SHORT_FIXED = 4'd1,
      ST_BAD_VERSION = 4'd2,
      ST_SHORT_CSRC  = 4'd3,
      ST_ZERO_PAD    = 4'd4,
      ST_EXT_HEADER  = 4'd5,
      ST_EXT_BODY    = 4'd6,
      ST_PAD_LARGE   = 4'd7,
      ST_TOO_LONG    = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_ONE   = 2'd1,
      KIND_TWO   = 2'd2,
      KIND_OTHER = 2'd3
   } ext_kind_type;

   // Packet state captured at the last byte
   typedef struct packed {
      logic [COUNT_W-1:0] size;
      logic [15:0]        flags;
      logic [15:0]        sequence_num;
      logic [31:0]        timestamp;
      logic [31:0]        source_id;
      logic [31:0]        ext_word;
      logic [7:0]         final_byte;
      logic               overflow;
   } snap_type;

   // Result fields, first field in the top bits so the last lands lowest
   typedef struct packed {
      logic [7:0]   padding_length;
      logic [11:0]  payload_length;
      logic [11:0]  payload_offset;
      ext_kind_type extension_kind;
      logic [3:0]   csrc_count;
      logic [31:0]  source_id;
      logic [31:0]  timestamp;
      logic [15:0]  sequence_res;
      logic [6:0]   payload_type;
      logic         marker;
      status_type   status;
   } result_type;

endpackage

### rtl/rhp_eval.sv
// Header checks and payload layout from a captured packet.
`timescale 1ns / 1ps
module rhp_eval (
   input  rhp_pkg::snap_type   snap_i,
   output rhp_pkg::result_type result_o
);
   import rhp_pkg::*;

   logic [7:0]   b0;
   logic [7:0]   b1;
   logic [3:0]   cc;
   logic         has_pad;
   logic         has_ext;
   logic [6:0]   off_base;
   logic [19:0]  size_w;
   logic [19:0]  ext_hdr_end;
   logic [19:0]  ext_end;
   logic [19:0]  offset;
   logic [19:0]  pay_end;
   logic [19:0]  plen;
   logic [7:0]   pad;
   logic         hdr_ok;
   status_type   status;
   ext_kind_type kind;
   ext_kind_type prof_kind;

   assign b0       = snap_i.flags[15:8];
   assign b1       = snap_i.flags[7:0];
   assign cc       = b0[3:0];
   assign has_pad  = b0[5];
   assign has_ext  = b0[4];
   assign off_base = FIXED_HDR_BYTES + {1'b0, cc, 2'b00};
   assign size_w   = 20'(snap_i.size);
   assign ext_hdr_end = 20'(off_base) + 20'd4;
   assign ext_end  = ext_hdr_end + 20'({snap_i.ext_word[15:0], 2'b00});

   // Classify the extension profile
   always_comb begin
      priority if (snap_i.ext_word[31:16] == PROFILE_ONE) begin
         prof_kind = KIND_ONE;
      end else if (snap_i.ext_word[31:16] == PROFILE_TWO) begin
         prof_kind = KIND_TWO;
      end else begin
         prof_kind = KIND_OTHER;
      end
   end

   // Run the checks in order; the first failure names the status
   always_comb begin
      status  = ST_OK;
      kind    = KIND_NONE;
      pad     = 8'd0;
      offset  = 20'd0;
      plen    = 20'd0;
      hdr_ok  = 1'b0;
      pay_end = 20'd0;
      priority if (snap_i.overflow) begin
         status = ST_TOO_LONG;
      end else if (size_w < 20'(FIXED_HDR_BYTES)) begin
         status = ST_SHORT_FIXED;
      end else if (b0[7:6] != RTP_VERSION) begin
         status = ST_BAD_VERSION;
      end else begin
         hdr_ok = 1'b1;
         offset = 20'(off_base);
         if (size_w < 20'(off_base)) begin
            status = ST_SHORT_CSRC;
         end else begin
            if (has_pad) begin
               pad = snap_i.final_byte;
            end
            if (has_pad && snap_i.final_byte == 8'd0) begin
               status = ST_ZERO_PAD;
            end else if (has_ext) begin
               if (ext_hdr_end > size_w) begin
                  status = ST_EXT_HEADER;
               end else begin
                  kind = prof_kind;
                  if (ext_end > size_w) begin
                     status = ST_EXT_BODY;
                  end else begin
                     offset = ext_end;
                  end
               end
            end
            pay_end = offset + 20'(pad);
            if (status == ST_OK) begin
               if (pay_end > size_w) begin
                  status = ST_PAD_LARGE;
               end else begin
                  plen = size_w - pay_end;
               end
            end
         end
      end
      // Drop the layout on any failure, and padding on early ones
      if (status != ST_OK) begin
         offset = 20'd0;
         plen   = 20'd0;
         if (status == ST_SHORT_FIXED || status == ST_BAD_VERSION ||
             status == ST_SHORT_CSRC || status == ST_ZERO_PAD ||
             status == ST_TOO_LONG) begin
            pad = 8'd0;
         end
      end
   end

   // Assemble the result
   always_comb begin
      result_o                = '0;
      result_o.status         = status;
      result_o.extension_kind = kind;
      result_o.payload_offset = offset[11:0];
      result_o.payload_length = plen[11:0];
      result_o.padding_length = pad;
      if (hdr_ok) begin
         result_o.marker       = b1[7];
         result_o.payload_type = b1[6:0];
         result_o.sequence_res = snap_i.sequence_num;
         result_o.timestamp    = snap_i.timestamp;
         result_o.source_id    = snap_i.source_id;
         result_o.csrc_count   = cc;
      end
   end

endmodule

### rtl/rtp_header_parser_core.sv
// Top level of the RTP header parser: byte capture, snapshot and result register.
`timescale 1ns / 1ps
// Takes an RTP packet one byte per transfer on the req_ bus, tlast on the final
// byte, and gives one result transfer per packet on the rsp_ bus. A byte is
// taken every cycle while the bus is free; the header fields are captured as
// they pass. The final byte copies the packet state into a snapshot register
// and clears the capture state, so the next packet may start in the very next
// cycle. The checks run between the snapshot and the result register: the final
// byte's state is registered in the snapshot, and its result is then registered
// in the result register, which drives rsp_tvalid. req_tready drops only when both
// the snapshot and the result register hold undelivered results. Packets longer
// than MAX_PACKET_BYTES are drained and reported as too long.
module rtp_header_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rhp_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] status, [4] marker, [11:5] payload_type, [27:12] sequence_res,
   // [59:28] timestamp, [91:60] source_id, [95:92] csrc_count,
   // [97:96] extension_kind, [109:98] payload_offset, [121:110] payload_length,
   // [129:122] padding_length, [135:130] zero
   output logic [rhp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rhp_pkg::*;

   // Capture state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        flags_ff, flags_in;
   logic [15:0]        seq_ff, seq_in;
   logic [31:0]        ts_ff, ts_in;
   logic [31:0]        src_ff, src_in;
   logic [31:0]        ext_ff, ext_in;
   logic [7:0]         final_in;
   logic               ovf_ff, ovf_in;

   // Snapshot and result stages
   snap_type           snap_ff, snap_in;
   logic               snap_vld_ff, snap_vld_in;
   result_type         res_ff, res_in;
   logic               res_vld_ff, res_vld_in;

   logic               byte_xfer;
   logic               last_xfer;
   logic               res_free;
   logic               snap_free;
   logic [6:0]         ext_off;
   logic [COUNT_W-1:0] ext_lo;
   logic [COUNT_W-1:0] ext_hi;
   logic [7:0]         din;

   assign din        = req_tdata[7:0];
   assign res_free   = !res_vld_ff || rsp_tready;
   assign snap_free  = !snap_vld_ff || res_free;
   assign req_tready = snap_free;
   assign byte_xfer  = req_tvalid && req_tready;
   assign last_xfer  = byte_xfer && req_tlast;

   assign ext_off = FIXED_HDR_BYTES + {1'b0, flags_ff[11:8], 2'b00};
   assign ext_lo  = COUNT_W'(ext_off);
   assign ext_hi  = COUNT_W'(ext_off) + COUNT_W'(4);

   // Shift the incoming byte into the header field that owns its position
   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      seq_in   = seq_ff;
      ts_in    = ts_ff;
      src_in   = src_ff;
      ext_in   = ext_ff;
      ovf_in   = ovf_ff;
      final_in = din;
      if (count_ff >= COUNT_W'(MAX_PACKET_BYTES)) begin
         ovf_in = 1'b1;
      end else begin
         priority if (count_ff < COUNT_W'(2)) begin
            flags_in = {flags_ff[7:0], din};
         end else if (count_ff < COUNT_W'(4)) begin
            seq_in = {seq_ff[7:0], din};
         end else if (count_ff < COUNT_W'(8)) begin
            ts_in = {ts_ff[23:0], din};
         end else if (count_ff < COUNT_W'(12)) begin
            src_in = {src_ff[23:0], din};
         end else begin
         end
         if (count_ff >= ext_lo && count_ff < ext_hi) begin
            ext_in = {ext_ff[23:0], din};
         end
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Capture registers: clear after the final byte of each packet
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '0;
         seq_ff   <= '0;
         ts_ff    <= '0;
         src_ff   <= '0;
         ext_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (last_xfer) begin
         count_ff <= '0;
         flags_ff <= '0;
         seq_ff   <= '0;
         ts_ff    <= '0;
         src_ff   <= '0;
         ext_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (byte_xfer) begin
         count_ff <= count_in;
         flags_ff <= flags_in;
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         src_ff   <= src_in;
         ext_ff   <= ext_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Snapshot stage: take the packet state including the final byte
   always_comb begin
      snap_in.size         = count_in;
      snap_in.flags        = flags_in;
      snap_in.sequence_num = seq_in;
      snap_in.timestamp    = ts_in;
      snap_in.source_id    = src_in;
      snap_in.ext_word     = ext_in;
      snap_in.final_byte   = final_in;
      snap_in.overflow     = ovf_in;
      snap_vld_in          = snap_vld_ff;
      if (snap_free) begin
         snap_vld_in = last_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
      end else begin
         snap_vld_ff <= snap_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_xfer) begin
         snap_ff <= snap_in;
      end
   end

   rhp_eval u_eval (
      .snap_i   (snap_ff),
      .result_o (res_in)
   );

   // Result register: load when free, hold while the consumer stalls
   always_comb begin
      res_vld_in = res_vld_ff;
      if (res_free) begin
         res_vld_in = snap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else begin
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && snap_vld_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_vld_ff;
   assign rsp_tdata  = {6'd0, res_ff};

   // Checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_PACKET_BYTES))
      else $error("byte count beyond packet limit");

   a_last_to_snap : assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> snap_vld_ff)
      else $error("final byte transfer lost before snapshot");

   a_fail_no_layout : assert property (@(posedge clock) disable iff (reset)
      (res_vld_ff && res_ff.status != ST_OK) |->
         (res_ff.payload_offset == 12'd0 && res_ff.payload_length == 12'd0))
      else $error("layout given on a failed packet");

   a_ok_offset : assert property (@(posedge clock) disable iff (reset)
      (res_vld_ff && res_ff.status == ST_OK) |->
         (res_ff.payload_offset >= 12'(FIXED_HDR_BYTES)))
      else $error("payload offset inside fixed header");

   a_state_cleared : assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> (count_ff == '0 && !ovf_ff))
      else $error("capture state not cleared after final byte");

endmodule
